FILE: hw/rtl/hbbc_pkg.sv
// ----------------------------------------------------------------------------
// hbbc_pkg
// types and constants shared by the hashed block buffer cache
// ----------------------------------------------------------------------------
package hbbc_pkg;

	localparam logic [2:0] REQ_GET     = 3'd0;
	localparam logic [2:0] REQ_RELEASE = 3'd1;
	localparam logic [2:0] REQ_PIN     = 3'd2;
	localparam logic [2:0] REQ_UNPIN   = 3'd3;
	localparam logic [2:0] REQ_MARK    = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_UNDER  = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	localparam logic [7:0] REFS_MAX = 8'hFF;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] device_id;
		logic [31:0] block_number;
		logic [4:0]  buffer_slot;
		logic [31:0] now_tick;
	} req_t;

	typedef struct packed {
		logic [4:0] slot_out;
		logic       was_hit;
		logic       needs_read;
		logic [1:0] status;
	} rsp_t;

	// one descriptor as held in the entry memory
	typedef struct packed {
		logic [31:0] device;
		logic [31:0] block;
		logic [31:0] stamp;
		logic [7:0]  refs;
		logic        valid;
		logic        assigned;
		logic [5:0]  bucket;     // bucket of block, sized for up to 64 buckets
		logic [31:0] join_order;
	} entry_t;

endpackage

FILE: hw/rtl/hashed_block_buffer_cache.sv
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// buffer descriptor cache with bucket hashing and timestamp lru replacement
// ----------------------------------------------------------------------------
// channel  direction  handshake           word
// req      in         req_valid/req_stall  req_t
// rsp      out        rsp_valid/rsp_stall  rsp_t
//
// descriptors live in one synchronous memory (one read port, one write port,
// registered read data). a get scans all entries once, evaluating the hit,
// bucket-reuse and global-claim candidates in the same pass; release, pin,
// unpin and mark valid skip the scan and reread only the addressed entry. the
// request bucket comes from a reciprocal multiply at accept, finished in the
// first scan cycle; each entry keeps its own bucket next to the descriptor.
// after reset a clearing pass writes every entry before the first word is
// taken. one request is in flight at a time; a stalled response sits in the
// output register while the next request is accepted.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache
	import hbbc_pkg::*;
#(
	parameter int NUM_BUFFERS = 32,
	parameter int NUM_BUCKETS = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int CW = $clog2(NUM_BUFFERS + 1);

	// block / NUM_BUCKETS as (block * RECIP) >> RSH, exact for 32-bit blocks
	localparam int RSH = 32 + $clog2(NUM_BUCKETS);
	localparam logic [32:0] RECIP = 33'(((65'd1 << RSH) + 65'(NUM_BUCKETS) - 65'd1)
		/ 65'(NUM_BUCKETS));

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_RD    = 7'b0001000,
		S_MOD   = 7'b0010000,
		S_WB    = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	entry_t mem [NUM_BUFFERS];
	entry_t rd_data_q;
	logic   we;
	logic [IW-1:0] waddr, raddr;
	entry_t wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_data_q <= mem[raddr];
	end

	req_t req_q;
	logic [CW-1:0] cnt_q;       // read issue counter
	logic [CW-1:0] rcnt_q;      // entry index of data arriving
	logic          rv_q;        // read data valid during scan
	logic [31:0]   join_q;
	logic [5:0]    bucket_q;
	logic [64:0]   prod_q;      // block times reciprocal, taken at accept

	// candidates
	logic          hit_f_q, bkt_f_q, gl_f_q;
	logic [IW-1:0] hit_i_q, bkt_i_q, gl_i_q;
	logic [31:0]   hit_j_q, bkt_j_q, bkt_s_q, gl_s_q;

	logic          out_full_q;
	logic          out_load;
	rsp_t          rsp_q;
	logic          res_hit_q, res_glob_q;
	logic [IW-1:0] tgt_q;
	rsp_t          res_q;
	rsp_t          wb_rsp;

	// remainder of the request block, from the registered product
	logic [31:0] quo, rem_full;
	assign quo = 32'(prod_q >> RSH);
	assign rem_full = req_q.block_number - quo * 32'(NUM_BUCKETS);

	logic slot_ok;
	assign slot_ok = {4'b0, req_q.buffer_slot} < 9'(NUM_BUFFERS);

	logic [IW-1:0] rid;
	assign rid = rcnt_q[IW-1:0];

	logic in_bkt;
	assign in_bkt = rd_data_q.assigned && (rd_data_q.bucket == bucket_q);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_full_q;
	assign rsp = rsp_q;
	assign out_load = (state_q == S_OUT) && (!out_full_q || !rsp_stall);

	entry_t nxt;
	always_comb begin
		nxt = rd_data_q;
		wb_rsp = res_q;
		we = 1'b0;
		waddr = tgt_q;
		wdata = rd_data_q;
		raddr = cnt_q[IW-1:0];
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = cnt_q[IW-1:0];
			wdata = '0;
			wdata.stamp = '1;
		end else if (state_q == S_RD) begin
			raddr = tgt_q;
		end else if (state_q == S_WB) begin
			if (req_q.req_type == REQ_GET) begin
				wb_rsp.slot_out = 5'(tgt_q);
				nxt.stamp = req_q.now_tick;
				if (res_q.status == ST_NOFREE) begin
					// no free entry: nothing written
					wb_rsp.slot_out = '0;
					wb_rsp.needs_read = 1'b0;
				end else if (res_hit_q) begin
					// hit at full count still gets the new stamp
					we = 1'b1;
					wb_rsp.needs_read = !rd_data_q.valid;
					if (rd_data_q.refs == REFS_MAX) wb_rsp.status = ST_SAT;
					else nxt.refs = rd_data_q.refs + 8'd1;
				end else begin
					we = 1'b1;
					wb_rsp.needs_read = 1'b1;
					nxt.device = req_q.device_id;
					nxt.block = req_q.block_number;
					nxt.valid = 1'b0;
					nxt.refs = 8'd1;
					nxt.bucket = bucket_q;
					if (res_glob_q) begin
						nxt.assigned = 1'b1;
						nxt.join_order = join_q;
					end
				end
			end else begin
				wb_rsp.was_hit = 1'b0;
				wb_rsp.needs_read = 1'b0;
				wb_rsp.status = ST_OK;
				wb_rsp.slot_out = req_q.buffer_slot;
				if (req_q.req_type > REQ_MARK) begin
					// unknown request: all fields zero
					wb_rsp.slot_out = '0;
				end else if (slot_ok) begin
					if (req_q.req_type == REQ_RELEASE || req_q.req_type == REQ_UNPIN) begin
						if (rd_data_q.refs == 8'd0) begin
							wb_rsp.status = ST_UNDER;
						end else begin
							we = 1'b1;
							nxt.refs = rd_data_q.refs - 8'd1;
						end
					end else if (req_q.req_type == REQ_PIN) begin
						if (rd_data_q.refs == REFS_MAX) begin
							wb_rsp.status = ST_SAT;
						end else begin
							we = 1'b1;
							nxt.refs = rd_data_q.refs + 8'd1;
						end
					end else begin
						we = 1'b1;
						nxt.valid = 1'b1;
					end
				end
			end
			wdata = nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			rcnt_q <= '0;
			rv_q <= 1'b0;
			join_q <= '0;
			out_full_q <= 1'b0;
			hit_f_q <= 1'b0;
			bkt_f_q <= 1'b0;
			gl_f_q <= 1'b0;
		end else begin
			if (out_load) out_full_q <= 1'b1;
			else if (out_full_q && !rsp_stall) out_full_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == CW'(NUM_BUFFERS - 1)) begin
						cnt_q <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						prod_q <= 65'(req.block_number) * 65'(RECIP);
						hit_f_q <= 1'b0;
						bkt_f_q <= 1'b0;
						gl_f_q <= 1'b0;
						cnt_q <= '0;
						rv_q <= 1'b0;
						tgt_q <= IW'(req.buffer_slot);
						if (req.req_type == REQ_GET) state_q <= S_SCAN;
						else state_q <= S_RD;
					end
				end
				S_SCAN: begin
					// bucket settles in the first cycle, before any data is used
					bucket_q <= rem_full[5:0];
					// issue reads, consume previous data
					rv_q <= (cnt_q < CW'(NUM_BUFFERS));
					rcnt_q <= cnt_q;
					if (cnt_q < CW'(NUM_BUFFERS)) cnt_q <= cnt_q + 1'b1;
					if (rv_q) begin
						if (in_bkt && rd_data_q.device == req_q.device_id &&
							rd_data_q.block == req_q.block_number &&
							(!hit_f_q || rd_data_q.join_order > hit_j_q)) begin
							hit_f_q <= 1'b1;
							hit_i_q <= rid;
							hit_j_q <= rd_data_q.join_order;
						end
						if (in_bkt && rd_data_q.refs == 8'd0 &&
							(!bkt_f_q || rd_data_q.stamp < bkt_s_q ||
							(rd_data_q.stamp == bkt_s_q && rd_data_q.join_order > bkt_j_q))) begin
							bkt_f_q <= 1'b1;
							bkt_i_q <= rid;
							bkt_s_q <= rd_data_q.stamp;
							bkt_j_q <= rd_data_q.join_order;
						end
						if (rd_data_q.refs == 8'd0 && (!gl_f_q || rd_data_q.stamp < gl_s_q)) begin
							gl_f_q <= 1'b1;
							gl_i_q <= rid;
							gl_s_q <= rd_data_q.stamp;
						end
					end
					if (rv_q && rcnt_q == CW'(NUM_BUFFERS - 1)) state_q <= S_MOD;
				end
				S_MOD: begin
					// choose target then reread it
					res_hit_q <= hit_f_q;
					res_glob_q <= !hit_f_q && !bkt_f_q;
					res_q.was_hit <= hit_f_q;
					res_q.status <= (!hit_f_q && !bkt_f_q && !gl_f_q) ? ST_NOFREE : ST_OK;
					if (hit_f_q) tgt_q <= hit_i_q;
					else if (bkt_f_q) tgt_q <= bkt_i_q;
					else tgt_q <= gl_i_q;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_WB;
				end
				S_WB: begin
					res_q <= wb_rsp;
					if (req_q.req_type == REQ_GET && res_q.status != ST_NOFREE &&
						!res_hit_q && res_glob_q)
						join_q <= join_q + 32'd1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						rsp_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> req_stall)
		else $error("request taken during scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_full_q && rsp_stall) |=> $stable(rsp_q))
		else $error("stalled response changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && res_glob_q && req_q.req_type == REQ_GET &&
		res_q.status != ST_NOFREE) |=> (join_q == $past(join_q) + 32'd1))
		else $error("join counter not advanced on global claim");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the hashed block buffer cache against a cycle-free model of its
// descriptor state: a directed table, saturation and no-free runs, then random
// get/release/pin/unpin/mark and unknown-type traffic on a small block pool,
// with random idling on both channels
module testbench;
	import hbbc_pkg::*;

	localparam int NBUF = 32;
	localparam int NBKT = 13;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// model copy of the descriptor memory
	logic [31:0] m_dev [NBUF];
	logic [31:0] m_blk [NBUF];
	logic [31:0] m_stamp [NBUF];
	logic [7:0] m_refs [NBUF];
	logic m_valid [NBUF];
	logic m_asg [NBUF];
	logic [31:0] m_join [NBUF];
	logic [31:0] m_join_ctr;

	rsp_t pending_rsp [$];
	int errors = 0;
	int words_sent = 0;
	int words_back = 0;
	int hits_seen = 0;
	int nofree_seen = 0;
	int cycle_cnt = 0;
	bit quiet_stall = 1'b0;
	bit quiet_valid = 1'b0;

	hashed_block_buffer_cache #(.NUM_BUFFERS(NBUF), .NUM_BUCKETS(NBKT)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic cache_clear();
		for (int i = 0; i < NBUF; i++) begin
			m_dev[i] = '0; m_blk[i] = '0; m_stamp[i] = '1; m_refs[i] = '0;
			m_valid[i] = 1'b0; m_asg[i] = 1'b0; m_join[i] = '0;
		end
		m_join_ctr = '0;
	endtask

	function automatic void rebind(int k, req_t r);
		m_dev[k] = r.device_id; m_blk[k] = r.block_number;
		m_valid[k] = 1'b0; m_refs[k] = 8'd1; m_stamp[k] = r.now_tick;
	endfunction

	// expected response of one request, state updated in place
	function automatic rsp_t cache_predict(req_t r);
		rsp_t o;
		int pick;
		logic [31:0] bkt;
		o = '0;
		pick = -1;
		bkt = r.block_number % NBKT;
		if (r.req_type == REQ_GET) begin
			for (int i = 0; i < NBUF; i++)
				if (m_asg[i] && m_blk[i] % NBKT == bkt && m_dev[i] == r.device_id
						&& m_blk[i] == r.block_number)
					if (pick < 0 || m_join[i] > m_join[pick]) pick = i;
			if (pick >= 0) begin
				m_stamp[pick] = r.now_tick;
				o.status = ST_OK;
				if (m_refs[pick] >= REFS_MAX) o.status = ST_SAT;
				else m_refs[pick]++;
				o.slot_out = 5'(pick); o.was_hit = 1'b1; o.needs_read = !m_valid[pick];
				return o;
			end
			// reuse a free entry of the same bucket, latest joiner on ties
			for (int i = 0; i < NBUF; i++)
				if (m_asg[i] && m_blk[i] % NBKT == bkt && m_refs[i] == 0)
					if (pick < 0 || m_stamp[i] < m_stamp[pick] ||
							(m_stamp[i] == m_stamp[pick] && m_join[i] > m_join[pick]))
						pick = i;
			if (pick >= 0) begin
				rebind(pick, r);
				o.slot_out = 5'(pick); o.needs_read = 1'b1;
				return o;
			end
			// global claim, lowest index on ties
			for (int i = 0; i < NBUF; i++)
				if (m_refs[i] == 0)
					if (pick < 0 || m_stamp[i] < m_stamp[pick]) pick = i;
			if (pick < 0) begin
				o.status = ST_NOFREE;
				return o;
			end
			rebind(pick, r);
			m_asg[pick] = 1'b1; m_join[pick] = m_join_ctr; m_join_ctr++;
			o.slot_out = 5'(pick); o.needs_read = 1'b1;
			return o;
		end
		if (r.req_type > REQ_MARK) return o;
		o.slot_out = r.buffer_slot;
		if (int'(r.buffer_slot) >= NBUF) return o;
		if (r.req_type == REQ_RELEASE || r.req_type == REQ_UNPIN) begin
			if (m_refs[r.buffer_slot] == 0) o.status = ST_UNDER;
			else m_refs[r.buffer_slot]--;
		end else if (r.req_type == REQ_PIN) begin
			if (m_refs[r.buffer_slot] >= REFS_MAX) o.status = ST_SAT;
			else m_refs[r.buffer_slot]++;
		end else
			m_valid[r.buffer_slot] = 1'b1;
		return o;
	endfunction

	// send one word; a typed expectation overrides the prediction when given
	task automatic send_word(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t p;
		while (!quiet_valid && $urandom_range(99) < 16) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		p = cache_predict(r);
		if (typed && p != typed_rsp) begin
			$error("table row disagrees with model: row %h model %h", typed_rsp, p);
			errors++;
		end
		pending_rsp.push_back(typed ? typed_rsp : p);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		words_sent++;
	endtask

	// receiver: random stall, compare field by field
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with nothing expected");
				errors++;
			end else begin
				rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp.slot_out !== e.slot_out) begin
					$error("slot_out expected %0d actual %0d", e.slot_out, rsp.slot_out);
					errors++;
				end
				if (rsp.was_hit !== e.was_hit) begin
					$error("was_hit expected %0d actual %0d", e.was_hit, rsp.was_hit);
					errors++;
				end
				if (rsp.needs_read !== e.needs_read) begin
					$error("needs_read expected %0d actual %0d", e.needs_read, rsp.needs_read);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					errors++;
				end
				if (e.was_hit) hits_seen++;
				if (e.status == ST_NOFREE) nofree_seen++;
			end
			words_back++;
		end
		rsp_stall <= quiet_stall ? 1'b0 : ($urandom_range(99) < 16);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic req_t mk(logic [2:0] t, logic [31:0] d, logic [31:0] b,
			int s, logic [31:0] n);
		req_t r;
		r.req_type = t; r.device_id = d; r.block_number = b;
		r.buffer_slot = 5'(s); r.now_tick = n;
		return r;
	endfunction

	typedef struct {
		req_t r;
		bit typed;
		rsp_t e;
	} table_row_t;

	function automatic rsp_t rs(int s, bit h, bit rd, logic [1:0] st);
		rsp_t o;
		o.slot_out = 5'(s); o.was_hit = h; o.needs_read = rd; o.status = st;
		return o;
	endfunction

	initial begin
		table_row_t rows [$];
		req_t r;
		int blk_pool;
		cache_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		rows.push_back('{mk(REQ_RELEASE, 0, 0, 5, 0), 1, rs(5, 0, 0, ST_UNDER)});
		rows.push_back('{mk(REQ_UNPIN, 0, 0, 0, 0), 1, rs(0, 0, 0, ST_UNDER)});
		rows.push_back('{mk(REQ_GET, '1, '1, 0, 0), 1, rs(0, 0, 1, ST_OK)});
		rows.push_back('{mk(REQ_GET, '1, '1, 0, 32'hFFFF_FFFE), 1, rs(0, 1, 1, ST_OK)});
		rows.push_back('{mk(REQ_MARK, 0, 0, 0, 0), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(REQ_GET, '1, '1, 31, 7), 1, rs(0, 1, 0, ST_OK)});
		rows.push_back('{mk(REQ_GET, 0, 0, 0, 3), 1, rs(1, 0, 1, ST_OK)});
		rows.push_back('{mk(3'd5, '1, '1, 31, '1), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(3'd7, 0, 0, 9, 0), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(3'd6, 1, 1, 1, 1), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(REQ_PIN, 0, 0, 31, 0), 1, rs(31, 0, 0, ST_OK)});
		rows.push_back('{mk(REQ_MARK, 0, 0, 30, 0), 1, rs(30, 0, 0, ST_OK)});
		rows.push_back('{mk(REQ_RELEASE, 0, 0, 1, 0), 0, '0});
		// same bucket reuse: block 13 maps with block 0
		rows.push_back('{mk(REQ_GET, 0, 13, 0, 9), 0, '0});
		rows.push_back('{mk(REQ_UNPIN, 0, 0, 31, 0), 0, '0});
		foreach (rows[i]) send_word(rows[i].r, rows[i].typed, rows[i].e);

		// saturate slot 2 with pins, then a hit at full count
		send_word(mk(REQ_GET, 5, 5, 0, 1), 0, '0);
		for (int i = 0; i < 256; i++) send_word(mk(REQ_PIN, 0, 0, 2, 0), 0, '0);
		send_word(mk(REQ_GET, 5, 5, 0, 2), 0, '0);

		// pin every entry so a miss finds no free buffer
		for (int i = 0; i < NBUF; i++) send_word(mk(REQ_PIN, 0, 0, i, 0), 0, '0);
		send_word(mk(REQ_GET, 77, 77, 0, 0), 1, rs(0, 0, 0, ST_NOFREE));

		// hold off until every expected response is back
		req_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		for (int i = 0; i < NBUF; i++) send_word(mk(REQ_RELEASE, 0, 0, i, 0), 0, '0);
		for (int i = 0; i < 256; i++) send_word(mk(REQ_UNPIN, 0, 0, 2, 0), 0, '0);

		// random traffic; a small block pool keeps hits and bucket reuse frequent
		for (int n = 0; n < 360; n++) begin
			quiet_valid = (n >= 120 && n < 220);
			quiet_stall = quiet_valid;
			blk_pool = (n % 200 < 100) ? 40 : 8;
			r.device_id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2);
			r.block_number = ($urandom_range(9) == 0) ? $urandom
				: $urandom_range(blk_pool);
			r.buffer_slot = 5'($urandom);
			r.now_tick = ($urandom_range(7) == 0) ? $urandom : (n * 3 + $urandom_range(4));
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6: r.req_type = REQ_GET;
				7, 8, 9, 10, 11: r.req_type = REQ_RELEASE;
				12, 13: r.req_type = REQ_PIN;
				14, 15: r.req_type = REQ_UNPIN;
				16, 17, 18: r.req_type = REQ_MARK;
				default: r.req_type = 3'(3'd5 + $urandom_range(2));
			endcase
			send_word(r, 0, '0);
		end
		quiet_valid = 0;
		quiet_stall = 0;
		req_valid <= 1'b0;

		wait (pending_rsp.size() == 0);
		repeat (2 * NBUF + 20) @(posedge clk);
		$display("sent %0d words, %0d responses, %0d hits, %0d no-free misses",
			words_sent, words_back, hits_seen, nofree_seen);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/hbbc_pkg.sv
hw/rtl/hashed_block_buffer_cache.sv
dv/testbench.sv
